// File: design/rhlr_pkg.sv
// Shared types and constant tables for the hires/lores pixel renderer.
`timescale 1ns / 1ps

package rhlr_pkg;

   localparam int PixelsMax = 16;
   localparam int ColorW    = 4;
   localparam int PixIdxW   = $clog2(PixelsMax);

   // One queued request: a color index for every pixel slot and the index of the last pixel.
   typedef struct packed {
      logic [PixelsMax-1:0][ColorW-1:0] colors;
      logic [PixIdxW-1:0]               last_idx;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   localparam logic [ColorW-1:0] ColorBlack = 4'd0;
   localparam logic [ColorW-1:0] ColorWhite = 4'd15;

   // Palette entries packed as {red, green, blue}.
   localparam logic [23:0] Palette [16] = '{
      24'h000000, 24'hD00030, 24'h000090, 24'hD020D0,
      24'h007020, 24'h505050, 24'h2020F0, 24'h60A0F0,
      24'h805000, 24'hF06000, 24'hA0A0A0, 24'hF09080,
      24'h10D000, 24'hF0F000, 24'h40F090, 24'hF0F0F0
   };

   // Hires window decode: [table][window][half], table 0 plain, table 1 shifted.
   localparam logic [ColorW-1:0] WinColor [2][16][2] = '{
      '{ '{4'd0, 4'd0},   '{4'd0, 4'd0},   '{4'd3, 4'd3},   '{4'd15, 4'd0},
         '{4'd12, 4'd12}, '{4'd12, 4'd12}, '{4'd15, 4'd15}, '{4'd15, 4'd15},
         '{4'd0, 4'd0},   '{4'd0, 4'd0},   '{4'd3, 4'd3},   '{4'd15, 4'd0},
         '{4'd0, 4'd15},  '{4'd0, 4'd15},  '{4'd15, 4'd15}, '{4'd15, 4'd15} },
      '{ '{4'd0, 4'd0},   '{4'd0, 4'd0},   '{4'd6, 4'd6},   '{4'd15, 4'd0},
         '{4'd9, 4'd9},   '{4'd9, 4'd9},   '{4'd15, 4'd15}, '{4'd15, 4'd15},
         '{4'd0, 4'd0},   '{4'd0, 4'd0},   '{4'd6, 4'd6},   '{4'd15, 4'd0},
         '{4'd0, 4'd15},  '{4'd0, 4'd15},  '{4'd15, 4'd15}, '{4'd15, 4'd15} }
   };

endpackage

// File: design/rgb_hires_lores_pixel_renderer.sv
// Top level of the hires/lores/text pixel renderer: front end, job queue and pixel back end.
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// req       in         req_valid/req_ready    disp_mode, mem_byte, glyph_bits, frame_start
// rsp       out        rsp_valid/rsp_ready    red, green, blue, last_pixel
//
// Each request produces 14 pixels in text and lores modes and 12 or 16 in hires modes.
// The back end emits one pixel per cycle while rsp is not stalled, and that single pixel
// port sets the sustained rate.
// The front end decodes a request in the cycle it arrives and queues it (two entries); the
// request being streamed keeps its entry, so one more request is accepted while it streams.
// Reset is synchronous and active high; it clears the counters, history and queue pointers.
// A stall on rsp holds the output register and the pixel index; requests keep being taken
// until the queue fills.

module rgb_hires_lores_pixel_renderer #(
   parameter int COLUMNS_PER_LINE = 40
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_disp_mode,
   input  logic [7:0]  req_mem_byte,
   input  logic [13:0] req_glyph_bits,
   input  logic        req_frame_start,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic        rsp_last_pixel
);
   import rhlr_pkg::*;

   queue_status_type q_status;
   job_type          q_push_data;
   job_type          q_pop_data;
   logic             q_push;
   logic             q_pop;

   // The front end owns the column, line and hires history state and turns each request
   // into a list of color indices with the position of the final pixel.
   rhlr_front #(
      .COLUMNS_PER_LINE(COLUMNS_PER_LINE)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_disp_mode  (req_disp_mode),
      .req_mem_byte   (req_mem_byte),
      .req_glyph_bits (req_glyph_bits),
      .req_frame_start(req_frame_start),
      .q_status       (q_status),
      .q_push         (q_push),
      .q_push_data    (q_push_data)
   );

   // The queue decouples decode from pixel streaming.
   rhlr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_data(q_push_data),
      .pop      (q_pop),
      .pop_data (q_pop_data),
      .status   (q_status)
   );

   // The back end looks up the palette and drives the registered pixel output.
   rhlr_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_status      (q_status),
      .q_data        (q_pop_data),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_red       (rsp_red),
      .rsp_green     (rsp_green),
      .rsp_blue      (rsp_blue),
      .rsp_last_pixel(rsp_last_pixel)
   );

endmodule

// File: design/rhlr_front.sv
// Front end: accepts requests, tracks column and line, and builds pixel color jobs.
`timescale 1ns / 1ps

module rhlr_front #(
   parameter int COLUMNS_PER_LINE = 40
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [2:0]                req_disp_mode,
   input  logic [7:0]                req_mem_byte,
   input  logic [13:0]               req_glyph_bits,
   input  logic                      req_frame_start,
   input  rhlr_pkg::queue_status_type q_status,
   output logic                      q_push,
   output rhlr_pkg::job_type         q_push_data
);
   import rhlr_pkg::*;

   localparam int ColW = (COLUMNS_PER_LINE > 1) ? $clog2(COLUMNS_PER_LINE) : 1;
   localparam logic [ColW-1:0] ColLast = ColW'(COLUMNS_PER_LINE - 1);
   localparam logic [7:0] MixedTextLine = 8'd160;
   localparam logic [7:0] LineMax       = 8'd255;

   localparam logic [2:0] ModeText       = 3'd0;
   localparam logic [2:0] ModeLores      = 3'd1;
   localparam logic [2:0] ModeHires      = 3'd2;
   localparam logic [2:0] ModeLoresMixed = 3'd3;
   localparam logic [2:0] ModeHiresMixed = 3'd4;

   logic [ColW-1:0] column_count_ff, column_count_in;
   logic [7:0]      line_count_ff, line_count_in;
   logic [6:0]      prev_hires_bits_ff, prev_hires_bits_in;
   logic            prev_shift_flag_ff, prev_shift_flag_in;

   logic [ColW-1:0] col;
   logic [7:0]      line;
   logic [6:0]      prev_bits;
   logic            prev_shift;
   logic [2:0]      mode;
   logic            is_lores, is_hires, wrap, shift;
   logic [9:0]      vbits;
   logic            four_windows;
   logic [3:0]      nibble;
   logic            accept;

   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;
   assign q_push    = accept;

   always_comb begin
      col        = req_frame_start ? '0 : column_count_ff;
      line       = req_frame_start ? '0 : line_count_ff;
      prev_bits  = req_frame_start ? '0 : prev_hires_bits_ff;
      prev_shift = req_frame_start ? 1'b0 : prev_shift_flag_ff;

      mode = req_disp_mode;
      if ((mode == ModeLoresMixed || mode == ModeHiresMixed) && line >= MixedTextLine) begin
         mode = ModeText;
      end
      is_lores = (mode == ModeLores) || (mode == ModeLoresMixed);
      is_hires = (mode == ModeHires) || (mode == ModeHiresMixed);
      shift    = req_mem_byte[7];
      nibble   = line[2] ? req_mem_byte[7:4] : req_mem_byte[3:0];

      if (col[0]) begin
         vbits        = {1'b0, req_mem_byte[6:0], prev_bits[6:5]};
         four_windows = (col == ColLast);
      end else if (col != '0) begin
         vbits        = {req_mem_byte[6:0], prev_bits[6:4]};
         four_windows = 1'b1;
      end else begin
         vbits        = {2'b00, req_mem_byte[6:0], 1'b0};
         four_windows = 1'b0;
      end

      // Each pixel slot: window k/4, half (k%4)/2, so each half is shown twice.
      for (int k = 0; k < PixelsMax; k++) begin
         if (is_hires) begin
            q_push_data.colors[k] =
               WinColor[(shift || ((k / 4) == 0 && prev_shift)) ? 1 : 0]
                       [vbits[2*(k/4) +: 4]][(k % 4) / 2];
         end else if (is_lores) begin
            q_push_data.colors[k] = nibble;
         end else if (k < 14) begin
            q_push_data.colors[k] = req_glyph_bits[k] ? ColorWhite : ColorBlack;
         end else begin
            q_push_data.colors[k] = ColorBlack;
         end
      end

      if (is_hires) begin
         q_push_data.last_idx = four_windows ? PixIdxW'(15) : PixIdxW'(11);
      end else begin
         q_push_data.last_idx = PixIdxW'(13);
      end

      wrap               = (col == ColLast);
      column_count_in    = wrap ? '0 : col + 1'b1;
      line_count_in      = (wrap && line != LineMax) ? line + 8'd1 : line;
      prev_hires_bits_in = wrap ? '0 : (is_hires ? req_mem_byte[6:0] : prev_bits);
      prev_shift_flag_in = is_hires ? shift : prev_shift;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff    <= '0;
         line_count_ff      <= '0;
         prev_hires_bits_ff <= '0;
         prev_shift_flag_ff <= 1'b0;
      end else if (accept) begin
         column_count_ff    <= column_count_in;
         line_count_ff      <= line_count_in;
         prev_hires_bits_ff <= prev_hires_bits_in;
         prev_shift_flag_ff <= prev_shift_flag_in;
      end
   end

endmodule

// File: design/rhlr_queue.sv
// Two-entry job queue between the front end and the pixel back end.
`timescale 1ns / 1ps

module rhlr_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  rhlr_pkg::job_type          push_data,
   input  logic                       pop,
   output rhlr_pkg::job_type          pop_data,
   output rhlr_pkg::queue_status_type status
);
   import rhlr_pkg::*;

   localparam int Depth = 2;

   job_type    entry_ff [Depth];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign status.full  = (count_ff == 2'(Depth));
   assign status.empty = (count_ff == 2'd0);
   assign pop_data     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full || pop)
      else $error("queue written while full");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("queue read while empty");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(Depth))
      else $error("queue count beyond depth");

endmodule

// File: design/rhlr_back.sv
// Back end: steps through a job one pixel per cycle unless rsp stalls, and registers the RGB result.
`timescale 1ns / 1ps

module rhlr_back (
   input  logic                       clock,
   input  logic                       reset,
   input  rhlr_pkg::queue_status_type q_status,
   input  rhlr_pkg::job_type          q_data,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [7:0]                 rsp_red,
   output logic [7:0]                 rsp_green,
   output logic [7:0]                 rsp_blue,
   output logic                       rsp_last_pixel
);
   import rhlr_pkg::*;

   logic [PixIdxW-1:0] pix_idx_ff, pix_idx_in;
   logic               rsp_valid_ff;
   logic [23:0]        rgb_ff;
   logic               last_ff;
   logic               advance, is_last;

   assign advance   = !q_status.empty && (!rsp_valid_ff || rsp_ready);
   assign is_last   = (pix_idx_ff == q_data.last_idx);
   assign q_pop     = advance && is_last;
   assign pix_idx_in = is_last ? '0 : pix_idx_ff + 1'b1;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_red        = rgb_ff[23:16];
   assign rsp_green      = rgb_ff[15:8];
   assign rsp_blue       = rgb_ff[7:0];
   assign rsp_last_pixel = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         pix_idx_ff   <= pix_idx_in;
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rgb_ff  <= Palette[q_data.colors[pix_idx_ff]];
         last_ff <= is_last;
      end
   end

   a_pop_marks_last: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> rsp_valid_ff && last_ff)
      else $error("job retired without a last pixel");
   a_idx_in_job: assert property (@(posedge clock) disable iff (reset)
      !q_status.empty |-> pix_idx_ff <= q_data.last_idx)
      else $error("pixel index ran past the job");
   a_stall_holds_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> $stable(pix_idx_ff))
      else $error("pixel index moved during a stall");

endmodule

// File: sim/rhlr_pixel_checker.sv
// Display mode codes shared by the testbench, and the pixel checker for the renderer.
`timescale 1ns / 1ps

package rhlr_tb_pkg;

   typedef enum logic [2:0] {
      VmText       = 3'd0,
      VmLores      = 3'd1,
      VmHires      = 3'd2,
      VmLoresMixed = 3'd3,
      VmHiresMixed = 3'd4,
      VmSpare5     = 3'd5,
      VmSpare6     = 3'd6,
      VmSpare7     = 3'd7
   } disp_mode_type;

endpackage

module rhlr_pixel_checker #(
   parameter int COLUMNS_PER_LINE = 40
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [2:0]  req_disp_mode,
   input  logic [7:0]  req_mem_byte,
   input  logic [13:0] req_glyph_bits,
   input  logic        req_frame_start,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_red,
   input  logic [7:0]  rsp_green,
   input  logic [7:0]  rsp_blue,
   input  logic        rsp_last_pixel,
   output int          mismatch_count,
   output int          pixels_owed
);

   import rhlr_tb_pkg::*;

   localparam logic [3:0] Black       = 4'd0;
   localparam logic [3:0] White       = 4'd15;
   localparam logic [6:0] LastColumn  = 7'(COLUMNS_PER_LINE - 1);

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       last_pixel;
   } pixel_type;

   pixel_type  owed_pixels[$];
   int         fail_tally  = 0;
   logic [6:0] col_pos     = '0;
   logic [7:0] line_num    = '0;
   logic [6:0] hires_hist  = '0;
   logic       hist_shift  = 1'b0;

   function automatic logic [23:0] palette_rgb(logic [3:0] color);
      case (color)
         4'd0:    return 24'h000000;
         4'd1:    return 24'hD00030;
         4'd2:    return 24'h000090;
         4'd3:    return 24'hD020D0;
         4'd4:    return 24'h007020;
         4'd5:    return 24'h505050;
         4'd6:    return 24'h2020F0;
         4'd7:    return 24'h60A0F0;
         4'd8:    return 24'h805000;
         4'd9:    return 24'hF06000;
         4'd10:   return 24'hA0A0A0;
         4'd11:   return 24'hF09080;
         4'd12:   return 24'h10D000;
         4'd13:   return 24'hF0F000;
         4'd14:   return 24'h40F090;
         default: return 24'hF0F0F0;
      endcase
   endfunction

   // Color pair {first half, second half} of one 4-bit hires window.
   // The shifted table only moves the two hue entries.
   function automatic logic [7:0] window_pair(logic shifted, logic [3:0] win);
      logic [3:0] violet_hue;
      logic [3:0] green_hue;
      violet_hue = shifted ? 4'd6 : 4'd3;
      green_hue  = shifted ? 4'd9 : 4'd12;
      case (win)
         4'd2, 4'd10:              return {violet_hue, violet_hue};
         4'd3, 4'd11:              return {White, Black};
         4'd4, 4'd5:               return {green_hue, green_hue};
         4'd6, 4'd7, 4'd14, 4'd15: return {White, White};
         4'd12, 4'd13:             return {Black, White};
         default:                  return {Black, Black};
      endcase
   endfunction

   function automatic void owe_pixel(logic [3:0] color, logic last);
      logic [23:0] rgb;
      rgb = palette_rgb(color);
      owed_pixels.push_back('{red: rgb[23:16], green: rgb[15:8], blue: rgb[7:0],
                              last_pixel: last});
   endfunction

   // Works out the pixel run of one accepted request and advances the beam position.
   function automatic void render_byte(logic [2:0] mode_bits, logic [7:0] vbyte,
                                       logic [13:0] glyph, logic restart);
      disp_mode_type mode;
      logic [3:0]    nib;
      logic [10:0]   vbits;
      logic [7:0]    pair;
      int            count;
      mode = disp_mode_type'(mode_bits);
      if (restart) begin
         col_pos    = '0;
         line_num   = '0;
         hires_hist = '0;
         hist_shift = 1'b0;
      end
      if ((mode == VmLoresMixed || mode == VmHiresMixed) && line_num >= 8'd160) begin
         mode = VmText;
      end
      case (mode)
         VmLores, VmLoresMixed: begin
            nib = line_num[2] ? vbyte[7:4] : vbyte[3:0];
            for (int i = 0; i < 14; i++) owe_pixel(nib, i == 13);
         end
         VmHires, VmHiresMixed: begin
            if (col_pos[0]) begin
               vbits = {2'b00, vbyte[6:0], 2'b00} | {9'd0, hires_hist[6:5]};
               count = (col_pos == LastColumn) ? 4 : 3;
            end else if (col_pos != '0) begin
               vbits = {1'b0, vbyte[6:0], 3'b000} | {8'd0, hires_hist[6:4]};
               count = 4;
            end else begin
               vbits = {3'b000, vbyte[6:0], 1'b0};
               count = 3;
            end
            for (int w = 0; w < count; w++) begin
               pair = window_pair(vbyte[7] || (w == 0 && hist_shift), vbits[2*w +: 4]);
               owe_pixel(pair[7:4], 1'b0);
               owe_pixel(pair[7:4], 1'b0);
               owe_pixel(pair[3:0], 1'b0);
               owe_pixel(pair[3:0], w == count - 1);
            end
            hires_hist = vbyte[6:0];
            hist_shift = vbyte[7];
         end
         default: begin
            for (int i = 0; i < 14; i++) owe_pixel(glyph[i] ? White : Black, i == 13);
         end
      endcase
      if (col_pos >= LastColumn) begin
         col_pos    = '0;
         hires_hist = '0;
         if (line_num != 8'd255) line_num = line_num + 8'd1;
      end else begin
         col_pos = col_pos + 7'd1;
      end
   endfunction

   function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         fail_tally++;
         $error("%s: expected %0h, got %0h", name, want, got);
      end
   endfunction

   function automatic void check_pixel();
      pixel_type want;
      if (owed_pixels.size() == 0) begin
         fail_tally++;
         $error("pixel with no request behind it");
         return;
      end
      want = owed_pixels.pop_front();
      compare_field("red", want.red, rsp_red);
      compare_field("green", want.green, rsp_green);
      compare_field("blue", want.blue, rsp_blue);
      compare_field("last_pixel", {7'd0, want.last_pixel}, {7'd0, rsp_last_pixel});
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         owed_pixels.delete();
         col_pos    = '0;
         line_num   = '0;
         hires_hist = '0;
         hist_shift = 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            render_byte(req_disp_mode, req_mem_byte, req_glyph_bits, req_frame_start);
         end
         if (rsp_valid && rsp_ready) check_pixel();
      end
      pixels_owed    <= owed_pixels.size();
      mismatch_count <= fail_tally;
   end

endmodule

// File: sim/tb_rgb_hires_lores_pixel_renderer.sv
// Testbench top for the pixel renderer: stimulus, flow control, watchdog and verdict.
`timescale 1ns / 1ps

// The stimulus runs in three parts. A short directed part walks through every display
// mode, the glyph and byte extremes, the hires column kinds and the shift-bit
// carry between bytes. A random part then sends whole display lines that sometimes
// start a new frame and keep one mode per line, mixed with broken lines of random
// length, stray frame starts and per-request mode changes. The last part sends two
// full lines from a new frame; in that part neither side idles.
// All pixel checking is done by the checker instance, which watches both channels.

module tb_rgb_hires_lores_pixel_renderer;

   import rhlr_tb_pkg::*;

   localparam int Columns       = 40;
   localparam int WatchdogLimit = 1000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_disp_mode;
   logic [7:0]  req_mem_byte;
   logic [13:0] req_glyph_bits;
   logic        req_frame_start;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_red;
   logic [7:0]  rsp_green;
   logic [7:0]  rsp_blue;
   logic        rsp_last_pixel;

   int mismatch_count;
   int pixels_owed;
   int quiet_cycles = 0;

   // Random gaps on the request side and stalls on the pixel side are on while this
   // is set.
   bit idling_on = 1'b0;

   rgb_hires_lores_pixel_renderer #(
      .COLUMNS_PER_LINE(Columns)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_disp_mode  (req_disp_mode),
      .req_mem_byte   (req_mem_byte),
      .req_glyph_bits (req_glyph_bits),
      .req_frame_start(req_frame_start),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .rsp_last_pixel (rsp_last_pixel)
   );

   rhlr_pixel_checker #(
      .COLUMNS_PER_LINE(Columns)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_disp_mode  (req_disp_mode),
      .req_mem_byte   (req_mem_byte),
      .req_glyph_bits (req_glyph_bits),
      .req_frame_start(req_frame_start),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .rsp_last_pixel (rsp_last_pixel),
      .mismatch_count (mismatch_count),
      .pixels_owed    (pixels_owed)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The pixel side takes pixels in random stretches and, while idling is on, stalls in random
   // bursts. Each pass assigns rsp_ready once and then waits on clock edges, so the signal
   // never gets two assignments in one time step.
   initial begin
      forever begin
         if (idling_on && $urandom_range(0, 2) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   // The run is ended if neither channel moves anything for too long. The longest
   // correct quiet stretch is a request gap or a pixel stall.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WatchdogLimit) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // Presents one request and returns at the edge where it is accepted. While idling is
   // on, valid may first drop for a random burst.
   task automatic send_pixel_request(disp_mode_type mode, logic [7:0] vbyte,
                                     logic [13:0] glyph, logic new_frame);
      if (idling_on && $urandom_range(0, 2) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_disp_mode   <= mode;
      req_mem_byte    <= vbyte;
      req_glyph_bits  <= glyph;
      req_frame_start <= new_frame;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   initial begin
      int            sent;
      int            run_len;
      logic          line_restart;
      disp_mode_type line_mode;
      disp_mode_type mode;

      sent = 0;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_disp_mode   <= VmText;
      req_mem_byte    <= 8'h00;
      req_glyph_bits  <= 14'h0000;
      req_frame_start <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Text in all its mode codes with empty, full and alternating
      // glyph rows, then lores, then a line that starts in hires: the first column,
      // a byte with only the shift bit, a byte after a shifted one, a text byte in
      // the middle that must leave the hires history alone, and a frame start that
      // arrives in the middle of a line.
      idling_on = 1'b1;
      send_pixel_request(VmText,       8'h00, 14'h0000, 1'b1);
      send_pixel_request(VmText,       8'hFF, 14'h3FFF, 1'b0);
      send_pixel_request(VmSpare5,     8'h00, 14'h2AAA, 1'b0);
      send_pixel_request(VmSpare6,     8'h80, 14'h1555, 1'b0);
      send_pixel_request(VmSpare7,     8'h7F, 14'h0001, 1'b0);
      send_pixel_request(VmLores,      8'hA5, 14'h2000, 1'b0);
      send_pixel_request(VmLoresMixed, 8'h0F, 14'h3FFF, 1'b0);
      send_pixel_request(VmLores,      8'hF0, 14'h0000, 1'b0);
      send_pixel_request(VmHires,      8'h7F, 14'h0000, 1'b1);
      send_pixel_request(VmHires,      8'h80, 14'h0000, 1'b0);
      send_pixel_request(VmHires,      8'h55, 14'h0000, 1'b0);
      send_pixel_request(VmHiresMixed, 8'hFF, 14'h3FFF, 1'b0);
      send_pixel_request(VmText,       8'h00, 14'h3FFF, 1'b0);
      send_pixel_request(VmHires,      8'h2A, 14'h0000, 1'b0);
      send_pixel_request(VmHiresMixed, 8'hD5, 14'h0000, 1'b0);
      send_pixel_request(VmLores,      8'h00, 14'h0000, 1'b0);
      send_pixel_request(VmHires,      8'h00, 14'h0000, 1'b0);
      send_pixel_request(VmHires,      8'h80, 14'h3FFF, 1'b1);
      send_pixel_request(VmHiresMixed, 8'h7F, 14'h0000, 1'b0);
      send_pixel_request(VmLoresMixed, 8'h5A, 14'h0000, 1'b0);

      // Random part. Most lines are full and keep one mode; some are cut short or run
      // past the wrap, and a few requests carry a stray frame start or another mode.
      // Idling is switched per line, so some lines run with no gaps at all.
      while (sent < 300) begin
         idling_on    = ($urandom_range(0, 3) != 0);
         line_mode    = disp_mode_type'($urandom_range(0, 7));
         line_restart = ($urandom_range(0, 2) == 0);
         run_len      = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 60) : Columns;
         for (int k = 0; k < run_len; k++) begin
            mode = ($urandom_range(0, 9) == 0) ? disp_mode_type'($urandom_range(0, 7))
                                               : line_mode;
            send_pixel_request(mode, 8'($urandom_range(0, 255)),
                               14'($urandom_range(0, 16383)),
                               (k == 0 && line_restart) || $urandom_range(0, 99) == 0);
            sent++;
         end
      end

      // Last part with no idling: two full lines from a new frame, one mode per line
      // with an occasional request in another mode.
      idling_on = 1'b0;
      for (int ln = 0; ln < 2; ln++) begin
         line_mode = disp_mode_type'($urandom_range(0, 7));
         for (int k = 0; k < Columns; k++) begin
            mode = ($urandom_range(0, 15) == 0) ? disp_mode_type'($urandom_range(0, 7))
                                                : line_mode;
            send_pixel_request(mode, 8'($urandom_range(0, 255)),
                               14'($urandom_range(0, 16383)), ln == 0 && k == 0);
         end
      end
      req_valid <= 1'b0;

      // Drain the pixels still owed, then watch a little longer for extra ones.
      do @(posedge clock); while (pixels_owed != 0);
      repeat (40) @(posedge clock);

      if (mismatch_count == 0 && pixels_owed == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
